>>> src/isfd_pkg.sv
// Shared constants for the IMU serial frame decoder.
package isfd_pkg;

  localparam int FRAME_BYTES = 11;
  localparam int FILL_W = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] SYNC_BYTE  = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic [1:0] KIND_ACCEL = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_ANGLE = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd6;

  localparam int RAW_W    = 16;
  localparam int OFFSET_W = 24;
  localparam int GAIN_W   = 16;
  localparam int ANGLE_W  = 32;
  localparam int CHAN_W   = 2;

  localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd256;
  localparam logic [CHAN_W-1:0] CHANNELS_RESET = 2'd3;

  localparam int ANGLE_SCALE = 180;
  localparam int SUM_W       = 26;
  localparam int PROD_W      = SUM_W + GAIN_W;
  localparam int FRAC_BITS   = 8;
  localparam int Q_W         = PROD_W - FRAC_BITS;
  localparam int STEP_W      = $clog2(GAIN_W);

  localparam longint ANGLE_LIMIT = 64'sd1509949440;

endpackage

>>> src/isfd_angle_lane.sv
// One angle correction lane: scale, offset, bit-serial gain multiply, saturate.
module isfd_angle_lane import isfd_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [RAW_W-1:0]    raw_word,
  input  logic signed [OFFSET_W-1:0] offset,
  input  logic signed [GAIN_W-1:0]   gain,
  output logic                       done,
  output logic signed [ANGLE_W-1:0]  angle
);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GAIN_W - 1);
  localparam logic signed [Q_W-1:0] LIMIT_POS = Q_W'(ANGLE_LIMIT);
  localparam logic signed [Q_W-1:0] LIMIT_NEG = Q_W'(-ANGLE_LIMIT);

  logic signed [SUM_W-1:0]  sum;
  logic signed [PROD_W-1:0] mcand;
  logic signed [PROD_W-1:0] acc;
  logic [GAIN_W-1:0]        mplier;
  logic [STEP_W-1:0]        step;
  logic                     busy;
  logic signed [Q_W-1:0]    q;

  assign sum = SUM_W'(raw_word) * SUM_W'(ANGLE_SCALE) + SUM_W'(offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == STEP_LAST);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // The gain is walked from its low bit; its top bit carries negative weight.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= PROD_W'(sum);
      mplier <= gain;
      acc    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= (step == STEP_LAST) ? acc - mcand : acc + mcand;
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign q = acc[PROD_W-1:FRAC_BITS];

  always_comb begin
    if (q > LIMIT_POS) begin
      angle = ANGLE_W'(LIMIT_POS);
    end else if (q < LIMIT_NEG) begin
      angle = ANGLE_W'(LIMIT_NEG);
    end else begin
      angle = ANGLE_W'(q);
    end
  end

endmodule

>>> src/imu_serial_frame_decoder_unit.sv
// Top level of the IMU serial frame decoder: framing, control and result register.
// A byte that yields no result leaves the control idle, so such bytes can follow back to back.
// Acceleration, rate and overrun clear words pass through the emit state into the output register.
// Angle words follow their byte through 16 multiply steps, the lane done flag, write-back and emit.
// The next byte can be taken in the cycle after the result word loads, later if that word waits.
// Synchronous reset empties the frame, zeroes held angles and restores register defaults.
module imu_serial_frame_decoder_unit import isfd_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   frame_kind,
  output logic signed [RAW_W-1:0]      raw_x,
  output logic signed [RAW_W-1:0]      raw_y,
  output logic signed [RAW_W-1:0]      raw_z,
  output logic signed [ANGLE_W-1:0]    angle_out_x,
  output logic signed [ANGLE_W-1:0]    angle_out_y,
  output logic signed [ANGLE_W-1:0]    angle_out_z,
  output logic                         angle_seen,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                 state;
  logic [FILL_W-1:0]          fill;
  logic [7:0]                 frame [FRAME_BYTES];
  logic signed [RAW_W-1:0]    frame_raw [3];
  logic signed [RAW_W-1:0]    pend_raw [3];
  logic [1:0]                 pend_kind;
  logic signed [ANGLE_W-1:0]  held [3];
  logic                       angle_flag;
  logic signed [OFFSET_W-1:0] offset [3];
  logic signed [GAIN_W-1:0]   gain [3];
  logic [CHAN_W-1:0]          angle_channels;
  logic [2:0]                 lane_done;
  logic signed [ANGLE_W-1:0]  lane_angle [3];

  logic in_accept;
  logic frame_full;
  logic is_sync;
  logic decode_go;
  logic overrun;
  logic lane_start;
  logic out_load;
  logic [7:0] frame_type;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // The newest byte sits in frame[0], so frame byte j of a full store is at
  // position FRAME_BYTES-1-j.
  assign frame_full = (fill == FILL_W'(FRAME_BYTES));
  assign is_sync    = (rx_byte == SYNC_BYTE);
  assign decode_go  = in_accept && is_sync && frame_full;
  assign overrun    = in_accept && !is_sync && frame_full;
  assign frame_type = frame[FRAME_BYTES-2];
  assign lane_start = decode_go && (frame_type == TYPE_ANGLE);
  assign out_load   = (state == ST_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      frame_raw[i] = {frame[FRAME_BYTES-4-2*i], frame[FRAME_BYTES-3-2*i]};
    end
  end

  // Each lane scales, offsets and multiplies one axis.
  for (genvar g = 0; g < 3; g++) begin : g_lane
    isfd_angle_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .start    (lane_start),
      .raw_word (frame_raw[g]),
      .offset   (offset[g]),
      .gain     (gain[g]),
      .done     (lane_done[g]),
      .angle    (lane_angle[g])
    );
  end

  // Control state, held angles and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      fill           <= '0;
      angle_flag     <= 1'b0;
      out_valid      <= 1'b0;
      angle_channels <= CHANNELS_RESET;
      for (int i = 0; i < 3; i++) begin
        held[i]   <= '0;
        offset[i] <= '0;
        gain[i]   <= GAIN_RESET;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OFFSET_X: offset[0] <= cfg_data[OFFSET_W-1:0];
          REG_OFFSET_Y: offset[1] <= cfg_data[OFFSET_W-1:0];
          REG_OFFSET_Z: offset[2] <= cfg_data[OFFSET_W-1:0];
          REG_GAIN_X:   gain[0]   <= cfg_data[GAIN_W-1:0];
          REG_GAIN_Y:   gain[1]   <= cfg_data[GAIN_W-1:0];
          REG_GAIN_Z:   gain[2]   <= cfg_data[GAIN_W-1:0];
          REG_CHANNELS: angle_channels <= cfg_data[CHAN_W-1:0];
          default: ;
        endcase
      end

      // A sync byte or any byte arriving on a full store begins a new frame.
      if (in_accept) begin
        fill <= (is_sync || frame_full) ? FILL_W'(1) : fill + 1'b1;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (decode_go) begin
            case (frame_type)
              TYPE_ACCEL: state <= ST_EMIT;
              TYPE_RATE:  state <= ST_EMIT;
              TYPE_ANGLE: state <= ST_MUL;
              default:    state <= ST_IDLE;
            endcase
          end else if (overrun) begin
            for (int i = 0; i < 3; i++) begin
              held[i] <= '0;
            end
            state <= ST_EMIT;
          end
        end
        ST_MUL: begin
          if (&lane_done) begin
            for (int i = 0; i < 3; i++) begin
              if (CHAN_W'(i) < angle_channels) begin
                held[i] <= lane_angle[i];
              end
            end
            angle_flag <= 1'b1;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Frame store shift line, pending result fields and the output register.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      frame[0] <= rx_byte;
      for (int i = 1; i < FRAME_BYTES; i++) begin
        frame[i] <= frame[i-1];
      end
    end

    if (decode_go) begin
      case (frame_type)
        TYPE_ACCEL: pend_kind <= KIND_ACCEL;
        TYPE_RATE:  pend_kind <= KIND_RATE;
        default:    pend_kind <= KIND_ANGLE;
      endcase
      for (int i = 0; i < 3; i++) begin
        pend_raw[i] <= frame_raw[i];
      end
    end else if (overrun) begin
      pend_kind <= KIND_CLEAR;
      for (int i = 0; i < 3; i++) begin
        pend_raw[i] <= '0;
      end
    end

    if (out_load) begin
      frame_kind  <= pend_kind;
      raw_x       <= pend_raw[0];
      raw_y       <= pend_raw[1];
      raw_z       <= pend_raw[2];
      angle_out_x <= held[0];
      angle_out_y <= held[1];
      angle_out_z <= held[2];
      angle_seen  <= angle_flag;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(FRAME_BYTES))
    else $error("frame fill count passed the frame length");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_kind == KIND_CLEAR) |->
      (angle_out_x == 0) && (angle_out_y == 0) && (angle_out_z == 0))
    else $error("overrun clear result carries nonzero angles");

  a_angle_seen: assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_kind == KIND_ANGLE) |-> angle_seen)
    else $error("angle result without the angle seen flag");

  a_lane_state: assert property (@(posedge clk) disable iff (rst)
    lane_done[0] |-> (state == ST_MUL))
    else $error("angle lane finished outside the multiply state");

  a_lane_start: assert property (@(posedge clk) disable iff (rst)
    lane_start |=> (state == ST_MUL))
    else $error("angle frame did not enter the multiply state");
`endif

endmodule
